/* rtl/ppmd_range_decoder_assert.svh */
// Assertion macros for the PPMd range decoder.
// Used by the top level; expects signals clk and rst_n in scope.
`ifndef PPMD_RANGE_DECODER_ASSERT_SVH
`define PPMD_RANGE_DECODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PPMD_RD_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define PPMD_RD_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

/* rtl/ppmd_rd_pkg.sv */
// Shared types, constants and microcode ROM of the PPMd range decoder.
// No dependencies; imported by the interfaces and all modules.
`timescale 1ns / 1ps

package ppmd_rd_pkg;

  typedef logic [31:0] word_t;
  typedef logic [2:0]  owed_t;
  typedef logic [4:0]  pc_t;

  localparam word_t FULL_RANGE = 32'hFFFF_FFFF;
  localparam word_t TOP_VALUE  = 32'h0100_0000;
  localparam word_t SATURATED  = 32'hFFFF_FFFF;
  localparam owed_t OWED_START = 3'd4;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_QUERY  = 3'd1,
    OP_DECODE = 3'd2,
    OP_BYTE   = 3'd3,
    OP_EOI    = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ACT_NOP       = 4'd0,
    ACT_START     = 4'd1,
    ACT_DIV_RT    = 4'd2,
    ACT_DIV_CQ    = 4'd3,
    ACT_THR_Q     = 4'd4,
    ACT_MUL_START = 4'd5,
    ACT_CODE_SUB  = 4'd6,
    ACT_MUL_SIZE  = 4'd7,
    ACT_NORM      = 4'd8,
    ACT_SAT       = 4'd9,
    ACT_SHIFT     = 4'd10,
    ACT_SHIFT_EOI = 4'd11
  } act_t;

  typedef enum logic [2:0] {
    JC_NEXT    = 3'd0,
    JC_ALWAYS  = 3'd1,
    JC_BAD     = 3'd2,
    JC_NOOWE   = 3'd3,
    JC_DIVWAIT = 3'd4
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    pc_t   target;
    logic  emit;
  } ctrl_t;

  typedef struct packed {
    logic bad;
    logic owed_zero;
    logic div_busy;
  } stat_t;

  typedef struct packed {
    word_t threshold;
    owed_t bytes_needed;
    logic  finished_ok;
    logic  error;
  } res_t;

  localparam pc_t PC_START = 5'd0;
  localparam pc_t PC_QUERY = 5'd1;
  localparam pc_t PC_Q_W1  = 5'd3;
  localparam pc_t PC_Q_W2  = 5'd5;
  localparam pc_t PC_DEC   = 5'd7;
  localparam pc_t PC_D_W1  = 5'd9;
  localparam pc_t PC_SAT   = 5'd14;
  localparam pc_t PC_BYTE  = 5'd15;
  localparam pc_t PC_EOI   = 5'd17;
  localparam pc_t PC_EMIT  = 5'd19;

  localparam ctrl_t CTRL_NOP = '{act: ACT_NOP, cond: JC_NEXT, target: PC_EMIT, emit: 1'b0};

  function automatic ctrl_t mk(input act_t a, input cond_t c, input pc_t t);
    ctrl_t w;
    w.act    = a;
    w.cond   = c;
    w.target = t;
    w.emit   = 1'b0;
    return w;
  endfunction

  function automatic ctrl_t ucode_rom(input pc_t pc);
    ctrl_t w;
    w = CTRL_NOP;
    case (pc)
      5'd0:  w = mk(ACT_START,     JC_ALWAYS,  PC_EMIT);
      5'd1:  w = mk(ACT_NOP,       JC_BAD,     PC_SAT);
      5'd2:  w = mk(ACT_DIV_RT,    JC_NEXT,    PC_EMIT);
      5'd3:  w = mk(ACT_NOP,       JC_DIVWAIT, PC_Q_W1);
      5'd4:  w = mk(ACT_DIV_CQ,    JC_NEXT,    PC_EMIT);
      5'd5:  w = mk(ACT_NOP,       JC_DIVWAIT, PC_Q_W2);
      5'd6:  w = mk(ACT_THR_Q,     JC_ALWAYS,  PC_EMIT);
      5'd7:  w = mk(ACT_NOP,       JC_BAD,     PC_SAT);
      5'd8:  w = mk(ACT_DIV_RT,    JC_NEXT,    PC_EMIT);
      5'd9:  w = mk(ACT_NOP,       JC_DIVWAIT, PC_D_W1);
      5'd10: w = mk(ACT_MUL_START, JC_NEXT,    PC_EMIT);
      5'd11: w = mk(ACT_CODE_SUB,  JC_NEXT,    PC_EMIT);
      5'd12: w = mk(ACT_MUL_SIZE,  JC_NEXT,    PC_EMIT);
      5'd13: w = mk(ACT_NORM,      JC_ALWAYS,  PC_EMIT);
      5'd14: w = mk(ACT_SAT,       JC_ALWAYS,  PC_EMIT);
      5'd15: w = mk(ACT_NOP,       JC_NOOWE,   PC_EMIT);
      5'd16: w = mk(ACT_SHIFT,     JC_ALWAYS,  PC_EMIT);
      5'd17: w = mk(ACT_NOP,       JC_NOOWE,   PC_EMIT);
      5'd18: w = mk(ACT_SHIFT_EOI, JC_ALWAYS,  PC_EMIT);
      5'd19: begin
        w      = CTRL_NOP;
        w.emit = 1'b1;
      end
      default: begin
        w      = CTRL_NOP;
        w.emit = 1'b1;
      end
    endcase
    return w;
  endfunction

  function automatic pc_t dispatch(input logic [2:0] op);
    pc_t pc;
    case (op)
      OP_START:  pc = PC_START;
      OP_QUERY:  pc = PC_QUERY;
      OP_DECODE: pc = PC_DEC;
      OP_BYTE:   pc = PC_BYTE;
      OP_EOI:    pc = PC_EOI;
      default:   pc = PC_EMIT;
    endcase
    return pc;
  endfunction

endpackage

/* rtl/ppmd_rd_in_if.sv */
// Input channel of the PPMd range decoder: valid/ready plus command payload.
// Depends on ppmd_rd_pkg.
`timescale 1ns / 1ps

interface ppmd_rd_in_if import ppmd_rd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  word_t       total;
  word_t       sym_start;
  word_t       sym_size;
  logic [7:0]  data_byte;

  modport source (output valid, operation, total, sym_start, sym_size, data_byte,
                  input ready);
  modport sink   (input valid, operation, total, sym_start, sym_size, data_byte,
                  output ready);
endinterface

/* rtl/ppmd_rd_out_if.sv */
// Result channel of the PPMd range decoder: valid/ready plus status payload.
// Depends on ppmd_rd_pkg.
`timescale 1ns / 1ps

interface ppmd_rd_out_if import ppmd_rd_pkg::*; ();
  logic   valid;
  logic   ready;
  word_t  threshold;
  owed_t  bytes_needed;
  logic   finished_ok;
  logic   error;

  modport source (output valid, threshold, bytes_needed, finished_ok, error,
                  input ready);
  modport sink   (input valid, threshold, bytes_needed, finished_ok, error,
                  output ready);
endinterface

/* rtl/ppmd_rd_div.sv */
// Radix-2 restoring divider, 32-bit unsigned, one quotient bit per cycle.
// Depends on ppmd_rd_pkg.
`timescale 1ns / 1ps

module ppmd_rd_div import ppmd_rd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output logic  busy,
  output word_t quotient
);

  localparam int W = $bits(word_t);
  localparam int CW = $clog2(W + 1);

  word_t          rem_r, rem_nxt;
  word_t          quo_r, quo_nxt;
  word_t          dsr_r, dsr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [W:0]     trial;
  logic [W:0]     diff;

  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dsr_nxt = dsr_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dsr_nxt = divisor;
      cnt_nxt = CW'(W);
    end else if (cnt_r != '0) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

/* rtl/ppmd_rd_useq.sv */
// Microsequencer: step counter, control ROM fetch, dispatch and conditional jumps.
// Depends on ppmd_rd_pkg (ROM contents, control and status structs).
`timescale 1ns / 1ps

module ppmd_rd_useq import ppmd_rd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [2:0] op,
  input  stat_t      stat,
  input  logic       out_free,
  output ctrl_t      ctrl,
  output logic       busy
);

  typedef enum logic [1:0] {
    SQ_IDLE = 2'b01,
    SQ_RUN  = 2'b10
  } seq_t;

  seq_t  phase_r, phase_nxt;
  pc_t   pc_r, pc_nxt;
  ctrl_t word;
  logic  taken;

  always_comb begin
    word = ucode_rom(pc_r);
    case (word.cond)
      JC_ALWAYS:  taken = 1'b1;
      JC_BAD:     taken = stat.bad;
      JC_NOOWE:   taken = stat.owed_zero;
      JC_DIVWAIT: taken = stat.div_busy;
      default:    taken = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    pc_nxt    = pc_r;
    case (phase_r)
      SQ_IDLE: begin
        if (start) begin
          pc_nxt    = dispatch(op);
          phase_nxt = SQ_RUN;
        end
      end
      SQ_RUN: begin
        if (word.emit) begin
          // hold on the emit step until the output register frees
          if (out_free) phase_nxt = SQ_IDLE;
        end else if (taken) begin
          pc_nxt = word.target;
        end else begin
          pc_nxt = pc_r + pc_t'(1);
        end
      end
      default: phase_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= SQ_IDLE;
      pc_r    <= PC_EMIT;
    end else begin
      phase_r <= phase_nxt;
      pc_r    <= pc_nxt;
    end
  end

  assign busy = (phase_r == SQ_RUN);
  assign ctrl = busy ? word : CTRL_NOP;

endmodule

/* rtl/ppmd_rd_dpath.sv */
// Datapath: range/code/owed/error state, latched command, shared multiplier, divider.
// Depends on ppmd_rd_pkg and ppmd_rd_div.
`timescale 1ns / 1ps

module ppmd_rd_dpath import ppmd_rd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  word_t      total_in,
  input  word_t      sstart_in,
  input  word_t      ssize_in,
  input  logic [7:0] byte_in,
  input  ctrl_t      ctrl,
  output stat_t      stat,
  output res_t       res
);

  word_t range_r, range_nxt;
  word_t code_r, code_nxt;
  owed_t owed_r, owed_nxt;
  logic  err_r, err_nxt;
  word_t thr_r, thr_nxt;
  word_t prod_r, prod_nxt;
  word_t total_r, sstart_r, ssize_r;
  logic [7:0] byte_r;

  logic        div_start;
  word_t       div_dividend, div_divisor, div_q;
  logic        div_busy;
  word_t       mul_a;
  logic [63:0] mul_full;
  word_t       mul_y;
  logic [7:0]  shift_byte;
  word_t       code_sh, range_sh;
  owed_t       norm_cnt;

  assign div_start    = (ctrl.act == ACT_DIV_RT) || (ctrl.act == ACT_DIV_CQ);
  assign div_dividend = (ctrl.act == ACT_DIV_CQ) ? code_r : range_r;
  assign div_divisor  = (ctrl.act == ACT_DIV_CQ) ? div_q : total_r;

  ppmd_rd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign mul_a    = (ctrl.act == ACT_MUL_SIZE) ? ssize_r : sstart_r;
  assign mul_full = mul_a * div_q;
  assign mul_y    = mul_full[31:0];

  assign shift_byte = ((ctrl.act == ACT_SHIFT_EOI) || err_r) ? 8'h00 : byte_r;
  assign code_sh    = {code_r[23:0], shift_byte};
  assign range_sh   = (range_r < TOP_VALUE) ? {range_r[23:0], 8'h00} : range_r;

  always_comb begin
    if (range_r < 32'h0000_0100)      norm_cnt = 3'd3;
    else if (range_r < 32'h0001_0000) norm_cnt = 3'd2;
    else if (range_r < TOP_VALUE)     norm_cnt = 3'd1;
    else                              norm_cnt = 3'd0;
  end

  always_comb begin
    range_nxt = range_r;
    code_nxt  = code_r;
    owed_nxt  = owed_r;
    err_nxt   = err_r;
    thr_nxt   = thr_r;
    prod_nxt  = prod_r;
    if (load) thr_nxt = '0;
    case (ctrl.act)
      ACT_START: begin
        range_nxt = FULL_RANGE;
        code_nxt  = '0;
        owed_nxt  = OWED_START;
        err_nxt   = 1'b0;
      end
      ACT_THR_Q:     thr_nxt = div_q;
      ACT_MUL_START: prod_nxt = mul_y;
      ACT_CODE_SUB:  code_nxt = code_r - prod_r;
      ACT_MUL_SIZE:  range_nxt = mul_y;
      ACT_NORM: begin
        if (range_r == '0) begin
          err_nxt  = 1'b1;
          owed_nxt = '0;
        end else begin
          owed_nxt = norm_cnt;
        end
      end
      ACT_SAT: begin
        err_nxt = 1'b1;
        thr_nxt = SATURATED;
      end
      ACT_SHIFT, ACT_SHIFT_EOI: begin
        if (ctrl.act == ACT_SHIFT_EOI) err_nxt = 1'b1;
        code_nxt  = code_sh;
        range_nxt = range_sh;
        owed_nxt  = owed_r - owed_t'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= '0;
      code_r  <= '0;
      owed_r  <= '0;
      err_r   <= 1'b0;
    end else begin
      range_r <= range_nxt;
      code_r  <= code_nxt;
      owed_r  <= owed_nxt;
      err_r   <= err_nxt;
    end
    thr_r  <= thr_nxt;
    prod_r <= prod_nxt;
    if (load) begin
      total_r  <= total_in;
      sstart_r <= sstart_in;
      ssize_r  <= ssize_in;
      byte_r   <= byte_in;
    end
  end

  assign stat.bad       = (owed_r != '0) || (total_r == '0) || (total_r > range_r);
  assign stat.owed_zero = (owed_r == '0);
  assign stat.div_busy  = div_busy;

  assign res.threshold    = thr_r;
  assign res.bytes_needed = owed_r;
  assign res.finished_ok  = (code_r == '0) && !err_r;
  assign res.error        = err_r;

endmodule

/* rtl/ppmd_range_decoder.sv */
// Channel    Dir   Handshake      Payload
// in_ch      in    valid/ready    operation, total, sym_start, sym_size, data_byte
// out_ch     out   valid/ready    threshold, bytes_needed, finished_ok, error
//
// One command at a time. A decode and a threshold query wait on the radix-2 divider
// (one quotient bit per cycle) from the microprogram; data byte, end of input and
// start do not use it.
// Synchronous active-low reset clears range, code, owed count and error.
// A finished result waits in the output register; a new command is taken meanwhile
// and its emit step holds until out_ch drains.
// Top level of the PPMd range decoder. Depends on ppmd_rd_pkg, the channel
// interfaces, ppmd_rd_useq, ppmd_rd_dpath and ppmd_range_decoder_assert.svh.
`timescale 1ns / 1ps
`include "ppmd_range_decoder_assert.svh"

module ppmd_range_decoder import ppmd_rd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  ppmd_rd_in_if.sink    in_ch,
  ppmd_rd_out_if.source out_ch
);

  ctrl_t ctrl;
  stat_t stat;
  res_t  res;
  logic  seq_busy;
  logic  in_fire;
  logic  out_free;
  logic  emit_fire;

  logic  out_valid_r, out_valid_nxt;
  res_t  out_res_r;

  assign in_ch.ready = !seq_busy;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign emit_fire   = ctrl.emit && out_free;

  ppmd_rd_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .op       (in_ch.operation),
    .stat     (stat),
    .out_free (out_free),
    .ctrl     (ctrl),
    .busy     (seq_busy)
  );

  ppmd_rd_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .total_in  (in_ch.total),
    .sstart_in (in_ch.sym_start),
    .ssize_in  (in_ch.sym_size),
    .byte_in   (in_ch.data_byte),
    .ctrl      (ctrl),
    .stat      (stat),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_fire) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (emit_fire) out_res_r <= res;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.threshold    = out_res_r.threshold;
  assign out_ch.bytes_needed = out_res_r.bytes_needed;
  assign out_ch.finished_ok  = out_res_r.finished_ok;
  assign out_ch.error        = out_res_r.error;

  `PPMD_RD_ASSERT_NXT(a_busy_after_accept, in_fire, seq_busy, "sequencer idle after a transaction")
  `PPMD_RD_ASSERT_NXT(a_emit_holds, seq_busy && ctrl.emit && !out_free, seq_busy, "result dropped while output full")
  `PPMD_RD_ASSERT_IMP(a_div_in_cmd, stat.div_busy, seq_busy, "divider running with no command")
  `PPMD_RD_ASSERT_IMP(a_owed_range, out_valid_r, out_res_r.bytes_needed <= OWED_START, "owed byte count out of range")

endmodule
